[rtl/pcfm_pkg.sv]
// Package for the peak / centroid / FWHM meter.
// Holds field widths, the controller state type and the control/status structs.
// No dependencies.
`default_nettype none

package pcfm_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned AMP_W   = 16;
  localparam int unsigned TOL_W   = 10;
  localparam int unsigned WSUM_W  = 32;
  localparam int unsigned MSUM_W  = 48;
  localparam int unsigned PROD_W  = POS_W + AMP_W;
  localparam int unsigned FW_W    = POS_W + 1;
  localparam int unsigned CEN_W   = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(100);

  // restoring divider: one quotient bit per cycle over the whole moment sum
  localparam int unsigned DIV_STEPS = MSUM_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_DIV,
    ST_DONE
  } pcfm_state_t;

  typedef struct packed {
    logic accept;
    logic capture;
    logic div_step;
    logic load_out;
  } pcfm_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } pcfm_sts_t;

endpackage

`default_nettype wire

[rtl/pcfm_ctrl.sv]
// Sequencer for the peak / centroid / FWHM meter.
// Steps through sample accumulation, sweep capture, division and result load.
// Depends on pcfm_pkg.
`default_nettype none

module pcfm_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire                    in_last,
  output logic                   in_stall,
  input  pcfm_pkg::pcfm_sts_t    sts,
  output pcfm_pkg::pcfm_cmd_t    cmd
);

  pcfm_pkg::pcfm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcfm_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      pcfm_pkg::ST_RUN: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = pcfm_pkg::ST_FLUSH;
        end
      end
      pcfm_pkg::ST_FLUSH: begin
        // fold in the last product, snapshot the sweep, clear accumulators
        cmd.capture = 1'b1;
        state_nxt   = pcfm_pkg::ST_DIV;
      end
      pcfm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = pcfm_pkg::ST_DONE;
        end
      end
      pcfm_pkg::ST_DONE: begin
        // hold until the output register can take the result
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = pcfm_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = pcfm_pkg::ST_RUN;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/pcfm_dp.sv]
// Datapath for the peak / centroid / FWHM meter: accumulators, peak and
// half-maximum tracking, serial divider and output register.
// Depends on pcfm_pkg; driven by pcfm_ctrl through pcfm_cmd_t.
`default_nettype none

module pcfm_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  pcfm_pkg::pcfm_cmd_t                  cmd,
  output pcfm_pkg::pcfm_sts_t                  sts,
  input  wire                                  cfg_valid,
  input  wire  [pcfm_pkg::TOL_W-1:0]           cfg_tolerance_divisor,
  input  wire  [pcfm_pkg::POS_W-1:0]           in_position,
  input  wire  [pcfm_pkg::AMP_W-1:0]           in_amplitude,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [pcfm_pkg::FW_W-1:0]            out_full_width,
  output logic [pcfm_pkg::CEN_W-1:0]           out_centroid,
  output logic [pcfm_pkg::POS_W-1:0]           out_peak_position,
  output logic                                 out_width_found,
  output logic                                 out_centroid_valid
);

  localparam int unsigned POS_W  = pcfm_pkg::POS_W;
  localparam int unsigned AMP_W  = pcfm_pkg::AMP_W;
  localparam int unsigned TOL_W  = pcfm_pkg::TOL_W;
  localparam int unsigned WSUM_W = pcfm_pkg::WSUM_W;
  localparam int unsigned MSUM_W = pcfm_pkg::MSUM_W;
  localparam int unsigned PROD_W = pcfm_pkg::PROD_W;
  localparam int unsigned FW_W   = pcfm_pkg::FW_W;
  localparam int unsigned CEN_W  = pcfm_pkg::CEN_W;
  localparam int unsigned DCNT_W = pcfm_pkg::DCNT_W;
  localparam int unsigned DIFF_W = AMP_W + 2;
  localparam int unsigned MAG_W  = AMP_W + 1;
  localparam int unsigned LHS_W  = TOL_W + MAG_W;

  // configuration
  logic [TOL_W-1:0]  tol_r;

  // sweep state
  logic [AMP_W-1:0]  prev_amp_r;
  logic [AMP_W-1:0]  peak_amp_r;
  logic [POS_W-1:0]  peak_at_r;
  logic [POS_W-1:0]  half_at_r;
  logic              half_seen_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [MSUM_W-1:0] msum_r;
  logic [PROD_W-1:0] prod_r;
  logic              prod_v_r;

  // divider and captured result fields
  logic [MSUM_W-1:0] quo_r;
  logic [WSUM_W-1:0] rem_r;
  logic [WSUM_W-1:0] dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [FW_W-1:0]   fw_r;
  logic [POS_W-1:0]  pk_r;
  logic              hf_r;
  logic              cv_r;

  // output register
  logic              out_valid_r;
  logic [FW_W-1:0]   out_fw_r;
  logic [CEN_W-1:0]  out_cen_r;
  logic [POS_W-1:0]  out_pk_r;
  logic              out_hf_r;
  logic              out_cv_r;

  // per-sample logic
  logic              rise;
  logic [AMP_W-1:0]  peak_new;
  logic [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]  mag;
  logic [LHS_W-1:0]  lhs;
  logic              half_hit;
  logic [MSUM_W-1:0] msum_add;

  // divider step
  logic [WSUM_W:0]   rem_sh;
  logic              dv_ge;
  logic [WSUM_W:0]   rem_sub;

  // result shaping
  logic [CEN_W-1:0]  cen_val;
  logic              out_take;

  always_comb begin
    rise     = in_amplitude > prev_amp_r;
    peak_new = rise ? in_amplitude : peak_amp_r;
    diff     = {1'b0, in_amplitude, 1'b0} - {2'b00, peak_new};
    mag      = diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    lhs      = LHS_W'(tol_r) * LHS_W'(mag);
    half_hit = (peak_new != '0) && (lhs < LHS_W'({peak_new, 1'b0}));
    msum_add = msum_r + (prod_v_r ? MSUM_W'(prod_r) : '0);
  end

  always_comb begin
    rem_sh  = {rem_r, quo_r[MSUM_W-1]};
    dv_ge   = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_comb begin
    if (!cv_r) begin
      cen_val = '0;
    end else if (quo_r[MSUM_W-1:CEN_W] != '0) begin
      cen_val = '1;
    end else begin
      cen_val = quo_r[CEN_W-1:0];
    end
  end

  assign out_take     = out_valid_r && !out_stall;
  assign sts.out_busy = out_valid_r && out_stall;
  assign sts.div_last = cnt_r == DCNT_W'(pcfm_pkg::DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= pcfm_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_tolerance_divisor;
    end
  end

  // sweep accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.capture) begin
      prev_amp_r  <= '0;
      peak_amp_r  <= '0;
      peak_at_r   <= '0;
      half_at_r   <= '0;
      half_seen_r <= 1'b0;
      wsum_r      <= '0;
      msum_r      <= '0;
      prod_v_r    <= 1'b0;
    end else begin
      msum_r   <= msum_add;
      prod_v_r <= cmd.accept;
      if (cmd.accept) begin
        wsum_r     <= wsum_r + WSUM_W'(in_amplitude);
        prev_amp_r <= in_amplitude;
        peak_amp_r <= peak_new;
        if (rise) begin
          peak_at_r <= in_position;
        end
        if (half_hit) begin
          half_at_r   <= in_position;
          half_seen_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_r <= PROD_W'(in_position) * PROD_W'(in_amplitude);
    end
  end

  // snapshot and serial division
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      quo_r <= msum_add;
      rem_r <= '0;
      dvs_r <= wsum_r;
      cnt_r <= '0;
      fw_r  <= (half_seen_r && half_at_r > peak_at_r) ?
               {half_at_r - peak_at_r, 1'b0} : '0;
      pk_r  <= peak_at_r;
      hf_r  <= half_seen_r;
      cv_r  <= wsum_r != '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[MSUM_W-2:0], dv_ge};
      rem_r <= dv_ge ? rem_sub[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_fw_r  <= fw_r;
      out_cen_r <= cen_val;
      out_pk_r  <= pk_r;
      out_hf_r  <= hf_r;
      out_cv_r  <= cv_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_full_width     = out_fw_r;
  assign out_centroid       = out_cen_r;
  assign out_peak_position  = out_pk_r;
  assign out_width_found    = out_hf_r;
  assign out_centroid_valid = out_cv_r;

endmodule

`default_nettype wire

[rtl/peak_centroid_fwhm_meter_unit.sv]
// Top level of the peak / centroid / FWHM meter.
// Instantiates pcfm_ctrl and pcfm_dp; types and widths from pcfm_pkg.
//
//   channel | direction | handshake        | payload
//   in_     | input     | valid / stall    | position, amplitude, last
//   out_    | output    | valid / stall    | full_width, centroid, peak_position,
//           |           |                  | width_found, centroid_valid
//   cfg_    | input     | valid / ready    | tolerance_divisor
//
// Samples are taken one per cycle while a sweep accumulates.
// After a last sample, in_stall is high through the flush state, the serial divider
// (one quotient bit per cycle) and the load state.
// The load cycle repeats, with in_stall still high, while an earlier result is stalled.
// The result waits in an output register; the next sweep starts while it waits.
// rst_n is synchronous; it clears all sweep state and sets the divisor to 100.
`default_nettype none

module peak_centroid_fwhm_meter_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [pcfm_pkg::TOL_W-1:0]       cfg_tolerance_divisor,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [pcfm_pkg::POS_W-1:0]       in_position,
  input  wire  [pcfm_pkg::AMP_W-1:0]       in_amplitude,
  input  wire                              in_last,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [pcfm_pkg::FW_W-1:0]        out_full_width,
  output logic [pcfm_pkg::CEN_W-1:0]       out_centroid,
  output logic [pcfm_pkg::POS_W-1:0]       out_peak_position,
  output logic                             out_width_found,
  output logic                             out_centroid_valid
);

  pcfm_pkg::pcfm_cmd_t cmd;
  pcfm_pkg::pcfm_sts_t sts;

  assign cfg_ready = 1'b1;

  pcfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcfm_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_valid             (cfg_valid),
    .cfg_tolerance_divisor (cfg_tolerance_divisor),
    .in_position           (in_position),
    .in_amplitude          (in_amplitude),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_full_width        (out_full_width),
    .out_centroid          (out_centroid),
    .out_peak_position     (out_peak_position),
    .out_width_found       (out_width_found),
    .out_centroid_valid    (out_centroid_valid)
  );

`ifndef ASSERT_OFF
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> in_stall)
    else $error("input not stalled after last sample");

  a_cen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_centroid_valid) |-> (out_centroid == '0))
    else $error("centroid nonzero with zero weight");

  a_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_width_found) |-> (out_full_width == '0))
    else $error("full width nonzero without half-maximum point");

  a_issue_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out) |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");
`endif

endmodule

`default_nettype wire
